// ----- design/lexical_token_classifier_top_assert.svh -----
// Assertion macros shared by the lexical token classifier modules.
// Expects signals named clock and reset in the including module.
`ifndef LEXICAL_TOKEN_CLASSIFIER_TOP_ASSERT_SVH
`define LEXICAL_TOKEN_CLASSIFIER_TOP_ASSERT_SVH

// Condition that must hold at every clock edge out of reset
`define LTC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next
`define LTC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/ltc_pkg.sv -----
// Package for the lexical token classifier: token types, scan modes,
// character classes and the keyword table. No dependencies.
package ltc_pkg;

   localparam int OFFSET_BITS_DEFAULT = 32;
   localparam int LENGTH_BITS_DEFAULT = 8;
   localparam int KW_COUNT            = 12;
   localparam int QUEUE_DEPTH         = 4;

   typedef enum logic [2:0] {
      KIND_OPERATOR   = 3'd0,
      KIND_DELIMITER  = 3'd1,
      KIND_NUMBER     = 3'd2,
      KIND_KEYWORD    = 3'd3,
      KIND_IDENTIFIER = 3'd4
   } token_kind_type;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_NUM  = 2'd1,
      MODE_WORD = 2'd2
   } scan_mode_type;

   // One result token as it leaves the block
   typedef struct packed {
      token_kind_type kind;
      logic [7:0]     token_char;
      logic [7:0]     length;
      logic [3:0]     kw_index;
      logic [31:0]    start;
      logic           last;
   } token_type;

   // Up to two tokens pushed toward the output queue per request
   typedef struct packed {
      logic [1:0] count;
      token_type  tok0;
      token_type  tok1;
   } push_type;

   typedef struct packed {
      token_kind_type kind;
      logic [3:0]     index;
   } word_match_type;

   function automatic logic is_op(logic [7:0] c);
      return (c == "<") || (c == ">") || (c == "+") || (c == "-") ||
             (c == "/") || (c == "*") || (c == "=") || (c == "&") ||
             (c == "|") || (c == "#") || (c == "\\") || (c == "?");
   endfunction

   function automatic logic is_delim(logic [7:0] c);
      return (c == "{") || (c == "}") || (c == "(") || (c == ")") ||
             (c == ";") || (c == ",") || (c == "'") || (c == "\"");
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   // Keyword lengths, index order int float void main while for char
   // printf scanf include stdio return
   function automatic logic [3:0] kw_len(logic [3:0] k);
      logic [3:0] l;
      case (k)
         4'd0:    l = 4'd3;
         4'd1:    l = 4'd5;
         4'd2:    l = 4'd4;
         4'd3:    l = 4'd4;
         4'd4:    l = 4'd5;
         4'd5:    l = 4'd3;
         4'd6:    l = 4'd4;
         4'd7:    l = 4'd6;
         4'd8:    l = 4'd5;
         4'd9:    l = 4'd7;
         4'd10:   l = 4'd5;
         4'd11:   l = 4'd6;
         default: l = 4'd0;
      endcase
      return l;
   endfunction

   // Character at position pos of keyword k, zero past its end
   function automatic logic [7:0] kw_char(logic [3:0] k, logic [2:0] pos);
      logic [55:0] w;
      logic [3:0]  l;
      int          sel;
      case (k)
         4'd0:    w = 56'("int");
         4'd1:    w = 56'("float");
         4'd2:    w = 56'("void");
         4'd3:    w = 56'("main");
         4'd4:    w = 56'("while");
         4'd5:    w = 56'("for");
         4'd6:    w = 56'("char");
         4'd7:    w = 56'("printf");
         4'd8:    w = 56'("scanf");
         4'd9:    w = 56'("include");
         4'd10:   w = 56'("stdio");
         4'd11:   w = 56'("return");
         default: w = '0;
      endcase
      l = kw_len(k);
      if ({1'b0, pos} >= l) begin
         return 8'd0;
      end
      // literals are right aligned: first character sits in byte l-1 of w
      sel = int'(l) - 1 - int'(pos);
      return w[8*sel +: 8];
   endfunction

endpackage

// ----- design/ltc_scan.sv -----
// Scanner core of the lexical token classifier: run state and per-byte
// token generation. Depends on ltc_pkg and the assertion macro header.
`include "lexical_token_classifier_top_assert.svh"

module ltc_scan #(
   parameter int OFFSET_BITS = ltc_pkg::OFFSET_BITS_DEFAULT,
   parameter int LENGTH_BITS = ltc_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        ch,
   input  logic              eos,
   output ltc_pkg::push_type push
);

   localparam int KWC = ltc_pkg::KW_COUNT;

   ltc_pkg::scan_mode_type   mode_ff, mode_in, mode_s;
   logic [LENGTH_BITS-1:0]   run_length_ff, run_length_in, len_s;
   logic [OFFSET_BITS-1:0]   run_start_ff, run_start_in, start_s;
   logic [OFFSET_BITS-1:0]   byte_offset_ff, byte_offset_in;
   logic [KWC-1:0]           alive_ff, alive_in, alive_s;
   logic [KWC-1:0]           match_ext, match_first;
   logic                     taken, closing;
   logic                     v_close, v_char, v_eos;
   ltc_pkg::token_type       tok_close, tok_char, tok_eos;
   logic [1:0]               n_tok;

   // Word classification: lowest keyword index whose text is still alive
   // and whose length equals the run length
   function automatic ltc_pkg::word_match_type classify_word(
      logic [KWC-1:0] alive, logic [LENGTH_BITS-1:0] len);
      ltc_pkg::word_match_type r;
      r.kind  = ltc_pkg::KIND_IDENTIFIER;
      r.index = 4'd0;
      for (int k = KWC - 1; k >= 0; k--) begin
         if (alive[k] && (LENGTH_BITS'(ltc_pkg::kw_len(4'(k))) == len)) begin
            r.kind  = ltc_pkg::KIND_KEYWORD;
            r.index = 4'(k);
         end
      end
      return r;
   endfunction

   // Token for a number or word run
   function automatic ltc_pkg::token_type make_run(
      ltc_pkg::scan_mode_type mode, logic [LENGTH_BITS-1:0] len,
      logic [OFFSET_BITS-1:0] start, logic [KWC-1:0] alive);
      ltc_pkg::token_type      t;
      ltc_pkg::word_match_type wm;
      logic [LENGTH_BITS+7:0]  lw;
      logic [OFFSET_BITS+31:0] sw;
      wm = classify_word(alive, len);
      lw = {8'd0, len};
      sw = {32'd0, start};
      t.kind         = (mode == ltc_pkg::MODE_NUM) ? ltc_pkg::KIND_NUMBER : wm.kind;
      t.token_char   = 8'd0;
      t.length       = lw[7:0];
      t.kw_index     = (mode == ltc_pkg::MODE_NUM) ? 4'd0 : wm.index;
      t.start        = sw[31:0];
      t.last         = 1'b0;
      return t;
   endfunction

   // Keyword matching, one lane per keyword
   always_comb begin
      for (int k = 0; k < KWC; k++) begin
         match_ext[k]   = alive_ff[k] &&
                          (run_length_ff < LENGTH_BITS'(ltc_pkg::kw_len(4'(k)))) &&
                          (ch == ltc_pkg::kw_char(4'(k), run_length_ff[2:0]));
         match_first[k] = (ch == ltc_pkg::kw_char(4'(k), 3'd0));
      end
   end

   // Next state
   always_comb begin
      taken = 1'b0;
      unique case (mode_ff)
         ltc_pkg::MODE_NUM:  taken = ltc_pkg::is_digit(ch) || (ch == ".");
         ltc_pkg::MODE_WORD: taken = ltc_pkg::is_alpha(ch) || ltc_pkg::is_digit(ch) ||
                                     (ch == "_");
         default:            taken = 1'b0;
      endcase
      closing = (mode_ff == ltc_pkg::MODE_NUM || mode_ff == ltc_pkg::MODE_WORD) && !taken;

      mode_s  = taken ? mode_ff : ltc_pkg::MODE_IDLE;
      len_s   = run_length_ff;
      start_s = run_start_ff;
      alive_s = alive_ff;
      if (taken) begin
         if (mode_ff == ltc_pkg::MODE_WORD) begin
            alive_s = match_ext;
         end
         if (run_length_ff != {LENGTH_BITS{1'b1}}) begin
            len_s = run_length_ff + 1'b1;
         end
      end else begin
         len_s   = '0;
         alive_s = '1;
         if (ltc_pkg::is_digit(ch) || ltc_pkg::is_alpha(ch)) begin
            mode_s  = ltc_pkg::is_digit(ch) ? ltc_pkg::MODE_NUM : ltc_pkg::MODE_WORD;
            start_s = byte_offset_ff;
            len_s   = LENGTH_BITS'(1);
            alive_s = ltc_pkg::is_digit(ch) ? '1 : match_first;
         end
      end

      // end of stream flushes the run and restarts the offset
      if (eos) begin
         mode_in        = ltc_pkg::MODE_IDLE;
         run_length_in  = '0;
         alive_in       = '1;
         byte_offset_in = '0;
      end else begin
         mode_in        = mode_s;
         run_length_in  = len_s;
         alive_in       = alive_s;
         byte_offset_in = byte_offset_ff + 1'b1;
      end
      run_start_in = start_s;
   end

   // Outputs: close token, single-character token, end-of-stream token
   always_comb begin
      logic [OFFSET_BITS+31:0] hw;
      hw = {32'd0, byte_offset_ff};

      tok_close = make_run(mode_ff, run_length_ff, run_start_ff, alive_ff);
      tok_eos   = make_run(mode_s, len_s, start_s, alive_s);

      tok_char.kind       = ltc_pkg::is_op(ch) ? ltc_pkg::KIND_OPERATOR
                                               : ltc_pkg::KIND_DELIMITER;
      tok_char.token_char = ch;
      tok_char.length     = 8'd1;
      tok_char.kw_index   = 4'd0;
      tok_char.start      = hw[31:0];
      tok_char.last       = 1'b0;

      v_close = closing;
      v_char  = !taken && (ltc_pkg::is_op(ch) || ltc_pkg::is_delim(ch));
      v_eos   = eos && (mode_s != ltc_pkg::MODE_IDLE);
      n_tok   = {1'b0, v_close} + {1'b0, v_char} + {1'b0, v_eos};

      push.count = accept ? n_tok : 2'd0;
      push.tok0  = v_close ? tok_close : (v_char ? tok_char : tok_eos);
      push.tok1  = v_close ? (v_char ? tok_char : tok_eos) : tok_eos;
      push.tok0.last = (n_tok == 2'd1);
      push.tok1.last = (n_tok == 2'd2);
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= ltc_pkg::MODE_IDLE;
         run_length_ff  <= '0;
         run_start_ff   <= '0;
         byte_offset_ff <= '0;
         alive_ff       <= '1;
      end else if (accept) begin
         mode_ff        <= mode_in;
         run_length_ff  <= run_length_in;
         run_start_ff   <= run_start_in;
         byte_offset_ff <= byte_offset_in;
         alive_ff       <= alive_in;
      end
   end

   `LTC_ASSERT_NEXT(a_eos_restarts, accept && eos, (mode_ff == ltc_pkg::MODE_IDLE) && (byte_offset_ff == '0), "end of stream did not return scanner to idle")
   `LTC_ASSERT(a_idle_no_run, (mode_ff != ltc_pkg::MODE_IDLE) || (run_length_ff == '0), "idle scanner holds a run length")
   `LTC_ASSERT(a_last_on_second, (push.count != 2'd2) || (push.tok1.last && !push.tok0.last), "last flag not on final token of a request")

endmodule

// ----- design/ltc_queue.sv -----
// Output queue of the lexical token classifier: takes up to two tokens
// per cycle and hands them out one per beat. Depends on ltc_pkg.
`include "lexical_token_classifier_top_assert.svh"

module ltc_queue (
   input  logic               clock,
   input  logic               reset,
   input  ltc_pkg::push_type  push,
   output logic               space,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output ltc_pkg::token_type head
);

   localparam int DEPTH    = ltc_pkg::QUEUE_DEPTH;
   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   ltc_pkg::token_type  q_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, wr_next;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                pop;

   // Pointer and fill arithmetic
   always_comb begin
      pop        = rsp_tvalid && rsp_tready;
      wr_next    = wr_ptr_ff + 1'b1;
      wr_ptr_in  = wr_ptr_ff + PTR_BITS'(push.count);
      rd_ptr_in  = rd_ptr_ff + PTR_BITS'(pop);
      count_in   = count_ff + CNT_BITS'(push.count) - CNT_BITS'(pop);
      space      = (count_ff <= CNT_BITS'(DEPTH - 2));
      rsp_tvalid = (count_ff != '0);
      head       = q_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Token storage
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         q_ff[wr_ptr_ff] <= push.tok0;
      end
      if (push.count == 2'd2) begin
         q_ff[wr_next] <= push.tok1;
      end
   end

   `LTC_ASSERT(a_count_bound, count_ff <= CNT_BITS'(DEPTH), "queue fill above depth")
   `LTC_ASSERT(a_no_overflow, CNT_BITS'(push.count) <= CNT_BITS'(DEPTH) - count_ff, "push exceeds free queue entries")
   `LTC_ASSERT_NEXT(a_fill_grows, (push.count != 2'd0) && !pop, count_ff > $past(count_ff), "queue fill did not grow on push")

endmodule

// ----- design/lexical_token_classifier_top.sv -----
// Lexical token classifier: takes one source byte per request and returns
// a stream of tokens. A request is accepted in any cycle in which the output
// queue has room for two tokens, so text is scanned at one byte per cycle
// while it has room; a token is queued with the byte that completes it. A
// byte causes zero, one or two tokens, and the output drains one token per
// cycle while rsp_tready is high, so for bytes that give two tokens (a run
// closed by an operator or delimiter, or by an end-of-stream byte that starts
// a fresh run) the four-entry token queue holds the second. Number and word
// lengths saturate at 2^LENGTH_BITS-1 and offsets count modulo 2^OFFSET_BITS,
// restarting at zero after the byte marked with req_tlast. Depends on
// ltc_pkg, ltc_scan and ltc_queue.
module lexical_token_classifier_top #(
   parameter int OFFSET_BITS = ltc_pkg::OFFSET_BITS_DEFAULT,
   parameter int LENGTH_BITS = ltc_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tlast,   // end_of_stream
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [7:0] token_char, [15:8] lexeme_length,
                                    // [19:16] keyword_index, [51:20] start_offset,
                                    // [55:52] zero
   output logic [2:0]  rsp_tuser,   // [2:0] token_kind
   output logic        rsp_tlast    // last_of_run
);

   logic               accept;
   logic               space;
   ltc_pkg::push_type  push;
   ltc_pkg::token_type head;

   assign req_tready = space;
   assign accept     = req_tvalid && space;

   ltc_scan #(
      .OFFSET_BITS (OFFSET_BITS),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_scan (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .ch     (req_tdata),
      .eos    (req_tlast),
      .push   (push)
   );

   ltc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .space      (space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .head       (head)
   );

   // Result packing
   assign rsp_tdata = {4'd0, head.start, head.kw_index, head.length, head.token_char};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

endmodule
